[hdl/rgb888_to_display_pixel_top_assert.svh]
// Assertion macros shared by the pixel converter RTL.
// Needs clk and rst_n in scope at the point of use.
`ifndef RGB888_TO_DISPLAY_PIXEL_TOP_ASSERT_SVH
`define RGB888_TO_DISPLAY_PIXEL_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define RGBDP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pixel converter check failed");

// Next-cycle implication, checked outside reset
`define RGBDP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pixel converter check failed");

`endif

[hdl/rgbdp_pkg.sv]
// Shared types, constants and the fixed packing function of the pixel converter.
// No dependencies.
`default_nettype none

package rgbdp_pkg;

    localparam int LEVEL_W   = 8;
    localparam int DEPTH_W   = 6;
    localparam int MASK_W    = 32;
    localparam int PIXEL_W   = 32;
    localparam int KEY_W     = 40;
    localparam int PROD_W    = 40;
    localparam int REM_W     = 11;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEPTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GREEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BLUE  = 3'd3;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 6'd24;
    localparam logic [MASK_W-1:0]  RED_RESET   = 32'h00FF_0000;
    localparam logic [MASK_W-1:0]  GREEN_RESET = 32'h0000_FF00;
    localparam logic [MASK_W-1:0]  BLUE_RESET  = 32'h0000_00FF;

    localparam logic [KEY_W-1:0] KEY_RGB32  = 40'h00_FFFF_0020;
    localparam logic [KEY_W-1:0] KEY_BGR32  = 40'h00_00FF_FF20;
    localparam logic [KEY_W-1:0] KEY_RGB565 = 40'h00_00FF_E010;
    localparam logic [KEY_W-1:0] KEY_BGR565 = 40'h00_0007_FF10;
    localparam logic [KEY_W-1:0] KEY_RGB555 = 40'h00_007F_E010;
    localparam logic [KEY_W-1:0] KEY_BGR555 = 40'h00_0003_FF10;

    typedef enum logic [2:0] {
        MODE_RGB32,
        MODE_BGR32,
        MODE_RGB565,
        MODE_BGR565,
        MODE_RGB555,
        MODE_BGR555,
        MODE_SCALE
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [MASK_W-1:0]  red_field;
        logic [MASK_W-1:0]  green_field;
        logic [MASK_W-1:0]  blue_field;
    } cfg_t;

    // Stage load enables, one per pipeline register stage
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } adv_t;

    function automatic logic [PIXEL_W-1:0] pack_fixed(
        input mode_t              mode,
        input logic [LEVEL_W-1:0] r,
        input logic [LEVEL_W-1:0] g,
        input logic [LEVEL_W-1:0] b
    );
        logic [PIXEL_W-1:0] px;
        unique case (mode)
            MODE_RGB32:  px = {8'b0, r, g, b};
            MODE_BGR32:  px = {8'b0, b, g, r};
            MODE_RGB565: px = {16'b0, r[7:3], g[7:2], b[7:3]};
            MODE_BGR565: px = {16'b0, b[7:3], g[7:2], r[7:3]};
            MODE_RGB555: px = {17'b0, r[7:3], g[7:3], b[7:3]};
            MODE_BGR555: px = {17'b0, b[7:3], g[7:3], r[7:3]};
            MODE_SCALE:  px = '0;
        endcase
        return px;
    endfunction

endpackage

`default_nettype wire

[hdl/rgbdp_cfg.sv]
// Configuration registers and format decode of the pixel converter.
// Depends on rgbdp_pkg.
`default_nettype none

module rgbdp_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [rgbdp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rgbdp_pkg::MASK_W-1:0]     cfg_data,
    output rgbdp_pkg::cfg_t                       cfg
);

    logic [rgbdp_pkg::DEPTH_W-1:0] depth_reg, depth_next;
    logic [rgbdp_pkg::MASK_W-1:0]  red_reg, red_next;
    logic [rgbdp_pkg::MASK_W-1:0]  green_reg, green_next;
    logic [rgbdp_pkg::MASK_W-1:0]  blue_reg, blue_next;
    logic [rgbdp_pkg::KEY_W-1:0]   key;
    rgbdp_pkg::mode_t              mode;

    always_comb
    begin
        depth_next = depth_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                rgbdp_pkg::CFG_IDX_DEPTH: depth_next = cfg_data[rgbdp_pkg::DEPTH_W-1:0];
                rgbdp_pkg::CFG_IDX_RED:   red_next   = cfg_data;
                rgbdp_pkg::CFG_IDX_GREEN: green_next = cfg_data;
                rgbdp_pkg::CFG_IDX_BLUE:  blue_next  = cfg_data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= rgbdp_pkg::DEPTH_RESET;
            red_reg   <= rgbdp_pkg::RED_RESET;
            green_reg <= rgbdp_pkg::GREEN_RESET;
            blue_reg  <= rgbdp_pkg::BLUE_RESET;
        end
        else
        begin
            depth_reg <= depth_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    // Key: depth in the low byte, red|green masks above it
    always_comb
    begin
        key = {red_reg | green_reg, 2'b00, depth_reg};
        priority if (key == rgbdp_pkg::KEY_RGB32)  mode = rgbdp_pkg::MODE_RGB32;
        else if     (key == rgbdp_pkg::KEY_BGR32)  mode = rgbdp_pkg::MODE_BGR32;
        else if     (key == rgbdp_pkg::KEY_RGB565) mode = rgbdp_pkg::MODE_RGB565;
        else if     (key == rgbdp_pkg::KEY_BGR565) mode = rgbdp_pkg::MODE_BGR565;
        else if     (key == rgbdp_pkg::KEY_RGB555) mode = rgbdp_pkg::MODE_RGB555;
        else if     (key == rgbdp_pkg::KEY_BGR555) mode = rgbdp_pkg::MODE_BGR555;
        else                                       mode = rgbdp_pkg::MODE_SCALE;
    end

    assign cfg.mode        = mode;
    assign cfg.red_field   = red_reg;
    assign cfg.green_field = green_reg;
    assign cfg.blue_field  = blue_reg;

endmodule

`default_nettype wire

[hdl/rgbdp_scale.sv]
// Three-stage channel scaler: (level * mask) / 255, ANDed with the mask.
// Depends on rgbdp_pkg; stage enables come from the top level.
`default_nettype none

module rgbdp_scale (
    input  wire logic                             clk,
    input  wire rgbdp_pkg::adv_t                  adv,
    input  wire logic [rgbdp_pkg::LEVEL_W-1:0]    level,
    input  wire logic [rgbdp_pkg::MASK_W-1:0]     field_mask,
    output logic      [rgbdp_pkg::MASK_W-1:0]     scaled
);

    localparam int SUM_W = rgbdp_pkg::REM_W + 1;

    logic [rgbdp_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [rgbdp_pkg::MASK_W-1:0] q0_reg, q0_next;
    logic [rgbdp_pkg::REM_W-1:0]  xlow_reg, xlow_next;
    logic [rgbdp_pkg::MASK_W-1:0] scaled_reg, scaled_next;
    logic [rgbdp_pkg::PROD_W-1:0] q0_sum;
    logic [rgbdp_pkg::REM_W-1:0]  rem;
    logic [SUM_W-1:0]             corr_sum;
    logic [2:0]                   corr;
    logic [rgbdp_pkg::MASK_W-1:0] quot;

    // Stage 1: one 8 x 32 product
    assign prod_next = rgbdp_pkg::PROD_W'(level) * rgbdp_pkg::PROD_W'(field_mask);

    // Stage 2: under-estimate x/255 by x/256 + x/65536 + ...; falls short by at most 5
    assign q0_sum    = (prod_reg >> 8) + (prod_reg >> 16) + (prod_reg >> 24) + (prod_reg >> 32);
    assign q0_next   = q0_sum[rgbdp_pkg::MASK_W-1:0];
    assign xlow_next = prod_reg[rgbdp_pkg::REM_W-1:0];

    // Stage 3: remainder x - 255*q0 is below 1530, so 11 bits of it suffice
    always_comb
    begin
        rem         = xlow_reg - {q0_reg[2:0], 8'b0} + q0_reg[rgbdp_pkg::REM_W-1:0];
        corr_sum    = SUM_W'(rem) + SUM_W'(rem[rgbdp_pkg::REM_W-1:8]) + SUM_W'(1);
        corr        = corr_sum[10:8];
        quot        = q0_reg + rgbdp_pkg::MASK_W'(corr);
        scaled_next = quot & field_mask;
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            prod_reg <= prod_next;
        end
        if (adv.s2)
        begin
            q0_reg   <= q0_next;
            xlow_reg <= xlow_next;
        end
        if (adv.s3)
        begin
            scaled_reg <= scaled_next;
        end
    end

    assign scaled = scaled_reg;

endmodule

`default_nettype wire

[hdl/rgb888_to_display_pixel_top.sv]
// Top level of the RGB888 to display pixel converter: handshake, pipeline control, output.
// Depends on rgbdp_pkg, rgbdp_cfg, rgbdp_scale and rgb888_to_display_pixel_top_assert.svh.
//
//   Channel  Signals                                   Direction  Moves
//   config   cfg_we, cfg_index, cfg_data               in         register write, no wait
//   input    in_valid/in_ready, red/green/blue_level   in         one source pixel per request
//   output   out_valid/out_ready, pixel_word           out        one display word per request
//
// Throughput is one pixel per clock while the output is not stalled; four register stages,
// and out_valid rises once an accepted request has reached the last of them.
// The four register stages are: product, reciprocal estimate, correction and mask, output mux.
// Stages advance individually: a stage loads when it is empty or the next one loads, so
// bubbles collapse and a stalled output only blocks the input once all four stages are full.
// Reset clears the stage valid bits and loads the reset configuration; data registers are
// not reset. Configuration must only be changed while the pipeline is empty (not enforced).
`default_nettype none

module rgb888_to_display_pixel_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [rgbdp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rgbdp_pkg::MASK_W-1:0]     cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [rgbdp_pkg::LEVEL_W-1:0]    red_level,
    input  wire logic [rgbdp_pkg::LEVEL_W-1:0]    green_level,
    input  wire logic [rgbdp_pkg::LEVEL_W-1:0]    blue_level,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic      [rgbdp_pkg::PIXEL_W-1:0]    pixel_word
);

`include "rgb888_to_display_pixel_top_assert.svh"

    rgbdp_pkg::cfg_t cfg;
    rgbdp_pkg::adv_t adv;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic s4_valid_reg, s4_valid_next;

    logic [rgbdp_pkg::PIXEL_W-1:0] fixed_s1_reg, fixed_s1_next;
    logic [rgbdp_pkg::PIXEL_W-1:0] fixed_s2_reg;
    logic [rgbdp_pkg::PIXEL_W-1:0] fixed_s3_reg;
    logic [rgbdp_pkg::PIXEL_W-1:0] pixel_reg, pixel_next;

    logic [rgbdp_pkg::MASK_W-1:0] red_scaled;
    logic [rgbdp_pkg::MASK_W-1:0] green_scaled;
    logic [rgbdp_pkg::MASK_W-1:0] blue_scaled;

    rgbdp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Advance a stage when it is empty or its contents move on
    always_comb
    begin
        adv.s4 = !s4_valid_reg || out_ready;
        adv.s3 = !s3_valid_reg || adv.s4;
        adv.s2 = !s2_valid_reg || adv.s3;
        adv.s1 = !s1_valid_reg || adv.s2;
    end

    assign s1_valid_next = adv.s1 ? in_valid     : s1_valid_reg;
    assign s2_valid_next = adv.s2 ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = adv.s3 ? s2_valid_reg : s3_valid_reg;
    assign s4_valid_next = adv.s4 ? s3_valid_reg : s4_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    // One scaler per channel; each follows the same stage enables
    rgbdp_scale u_scale_red (
        .clk        (clk),
        .adv        (adv),
        .level      (red_level),
        .field_mask (cfg.red_field),
        .scaled     (red_scaled)
    );

    rgbdp_scale u_scale_green (
        .clk        (clk),
        .adv        (adv),
        .level      (green_level),
        .field_mask (cfg.green_field),
        .scaled     (green_scaled)
    );

    rgbdp_scale u_scale_blue (
        .clk        (clk),
        .adv        (adv),
        .level      (blue_level),
        .field_mask (cfg.blue_field),
        .scaled     (blue_scaled)
    );

    // Fixed packings are pure wiring: build at entry and carry alongside the scalers
    assign fixed_s1_next = rgbdp_pkg::pack_fixed(cfg.mode, red_level, green_level, blue_level);

    // Output stage: pick the fixed packing or the ORed scaled channels
    assign pixel_next = (cfg.mode == rgbdp_pkg::MODE_SCALE)
                      ? (red_scaled | green_scaled | blue_scaled)
                      : fixed_s3_reg;

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            fixed_s1_reg <= fixed_s1_next;
        end
        if (adv.s2)
        begin
            fixed_s2_reg <= fixed_s1_reg;
        end
        if (adv.s3)
        begin
            fixed_s3_reg <= fixed_s2_reg;
        end
        if (adv.s4)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign in_ready   = adv.s1;
    assign out_valid  = s4_valid_reg;
    assign pixel_word = pixel_reg;

    // An accepted request always lands in the first stage
    `RGBDP_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, s1_valid_reg)
    // The input is held off only when every stage is full and the output is stalled
    `RGBDP_ASSERT_NOW(a_block_only_full, !in_ready,
        s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg && !out_ready)
    // A full third stage moving on must fill the output stage
    `RGBDP_ASSERT_NEXT(a_s3_to_out, s3_valid_reg && adv.s4, s4_valid_reg)
    // 16- and 15-bit packings leave the upper half clear
    `RGBDP_ASSERT_NOW(a_narrow_upper_zero,
        out_valid && (cfg.mode == rgbdp_pkg::MODE_RGB565 || cfg.mode == rgbdp_pkg::MODE_BGR565
        || cfg.mode == rgbdp_pkg::MODE_RGB555 || cfg.mode == rgbdp_pkg::MODE_BGR555),
        pixel_word[31:16] == 16'h0000)

endmodule

`default_nettype wire

[verif/pixel_word_checker.sv]
// Checker for the RGB888 to display pixel converter: watches the config port and both
// request channels, predicts each pixel_word and compares it in order.
// Depends on rgbdp_pkg.
module pixel_word_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [rgbdp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rgbdp_pkg::MASK_W-1:0]     cfg_data,
    input  wire logic                             in_valid,
    input  wire logic                             in_ready,
    input  wire logic [rgbdp_pkg::LEVEL_W-1:0]    red_level,
    input  wire logic [rgbdp_pkg::LEVEL_W-1:0]    green_level,
    input  wire logic [rgbdp_pkg::LEVEL_W-1:0]    blue_level,
    input  wire logic                             out_valid,
    input  wire logic                             out_ready,
    input  wire logic [rgbdp_pkg::PIXEL_W-1:0]    pixel_word,
    output int                                    mismatches,
    output int                                    pending
);
    import rgbdp_pkg::*;

    localparam logic [PROD_W-1:0]  FULL_LEVEL = 40'd255;
    localparam logic [PIXEL_W-1:0] TOP5       = 32'h0000_00F8;
    localparam logic [PIXEL_W-1:0] TOP6       = 32'h0000_00FC;
    localparam int                 PRINT_CAP  = 40;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        logic [PIXEL_W-1:0] pixel;
    } pixel_due_t;

    logic [DEPTH_W-1:0] depth_q;
    logic [MASK_W-1:0]  red_field_q;
    logic [MASK_W-1:0]  green_field_q;
    logic [MASK_W-1:0]  blue_field_q;
    pixel_due_t         pixels_due[$];

    initial mismatches = 0;

    function automatic logic [PIXEL_W-1:0] scale_level(
        input logic [LEVEL_W-1:0] level,
        input logic [MASK_W-1:0]  mask
    );
        logic [PROD_W-1:0] level_w;
        logic [PROD_W-1:0] mask_w;
        logic [PROD_W-1:0] quotient;
        level_w  = level;
        mask_w   = mask;
        quotient = (level_w * mask_w) / FULL_LEVEL;
        return quotient[PIXEL_W-1:0] & mask;
    endfunction

    // Selection key is depth OR'd with the red/green masks shifted up a byte, at 40 bits
    function automatic logic [PIXEL_W-1:0] convert_pixel(
        input logic [LEVEL_W-1:0] r,
        input logic [LEVEL_W-1:0] g,
        input logic [LEVEL_W-1:0] b
    );
        logic [KEY_W-1:0]   depth_w;
        logic [KEY_W-1:0]   masks_w;
        logic [KEY_W-1:0]   key;
        logic [PIXEL_W-1:0] rw;
        logic [PIXEL_W-1:0] gw;
        logic [PIXEL_W-1:0] bw;
        logic [PIXEL_W-1:0] px;
        depth_w = depth_q;
        masks_w = red_field_q | green_field_q;
        key     = depth_w | (masks_w << 8);
        rw      = r;
        gw      = g;
        bw      = b;
        case (key)
            KEY_RGB32:  px = (rw << 16) | (gw << 8) | bw;
            KEY_BGR32:  px = (bw << 16) | (gw << 8) | rw;
            KEY_RGB565: px = ((rw & TOP5) << 8) | ((gw & TOP6) << 3) | ((bw & TOP5) >> 3);
            KEY_BGR565: px = ((bw & TOP5) << 8) | ((gw & TOP6) << 3) | ((rw & TOP5) >> 3);
            KEY_RGB555: px = ((rw & TOP5) << 7) | ((gw & TOP5) << 2) | ((bw & TOP5) >> 3);
            KEY_BGR555: px = ((bw & TOP5) << 7) | ((gw & TOP5) << 2) | ((rw & TOP5) >> 3);
            default:    px = scale_level(r, red_field_q) | scale_level(g, green_field_q)
                             | scale_level(b, blue_field_q);
        endcase
        return px;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("[%0t] pixel check: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_due_t due;
        if (!rst_n)
        begin
            depth_q       <= DEPTH_RESET;
            red_field_q   <= RED_RESET;
            green_field_q <= GREEN_RESET;
            blue_field_q  <= BLUE_RESET;
            pixels_due.delete();
            pending       <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pixels_due.size() == 0)
                    report_mismatch($sformatf("pixel_word %h with nothing outstanding",
                                              pixel_word));
                else
                begin
                    due = pixels_due.pop_front();
                    if (pixel_word !== due.pixel)
                        report_mismatch($sformatf(
                            "rgb %h/%h/%h gave pixel_word %h, want %h",
                            due.red, due.green, due.blue, pixel_word, due.pixel));
                end
            end
            // Predict with the settings in force before this edge
            if (in_valid && in_ready)
            begin
                due.red   = red_level;
                due.green = green_level;
                due.blue  = blue_level;
                due.pixel = convert_pixel(red_level, green_level, blue_level);
                pixels_due.push_back(due);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IDX_DEPTH: depth_q       <= cfg_data[DEPTH_W-1:0];
                    CFG_IDX_RED:   red_field_q   <= cfg_data;
                    CFG_IDX_GREEN: green_field_q <= cfg_data;
                    CFG_IDX_BLUE:  blue_field_q  <= cfg_data;
                    default:       ;
                endcase
            end
            pending <= pixels_due.size();
        end
    end

endmodule

[verif/tb.sv]
// Testbench top for the RGB888 to display pixel converter: clock, reset, config writes,
// pixel requests, output back-pressure and the verdict.
// Depends on rgbdp_pkg, rgb888_to_display_pixel_top and pixel_word_checker.
module tb;
    import rgbdp_pkg::*;

    localparam int STALL_MAX    = 16;      // longest per-request gap on either side
    localparam int CHOKE_EVERY  = 700;     // receiver chokes once per this many results...
    localparam int CHOKE_AT     = 250;     // ...at this offset
    localparam int CHOKE_CYCLES = 300;
    localparam int DRAIN_CYCLES = 12;      // pipeline is four deep; leave room for strays
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NAMED_COUNT  = 6;       // fixed packing formats at the head of the list

    // One display format: depth and the three channel masks
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [MASK_W-1:0]  red;
        logic [MASK_W-1:0]  green;
        logic [MASK_W-1:0]  blue;
    } format_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MASK_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [LEVEL_W-1:0]   red_level;
    logic [LEVEL_W-1:0]   green_level;
    logic [LEVEL_W-1:0]   blue_level;
    logic                 out_valid;
    logic                 out_ready;
    logic [PIXEL_W-1:0]   pixel_word;
    int                   mismatches;
    int                   pending;

    // Per-phase switches that turn idling off on either side
    logic                 sender_brisk;
    logic                 receiver_brisk;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    rgb888_to_display_pixel_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_word  (pixel_word)
    );

    pixel_word_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_word  (pixel_word),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // Hold reset from the start, then release it for good
    initial
    begin
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Write one register; the write lands on the next rising edge. The caller drops
    // cfg_we once its run of writes is over, so back-to-back writes never toggle it.
    task automatic write_register(
        input logic [CFG_IDX_W-1:0] idx,
        input logic [MASK_W-1:0]    data
    );
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Load a whole format, then poke an index beyond the register file with junk,
    // which the block must ignore. Random upper bits ride along with the depth.
    task automatic apply_format(input format_t f);
        logic [MASK_W-1:0]    depth_word;
        logic [CFG_IDX_W-1:0] spare_index;
        depth_word                = $urandom;
        depth_word[DEPTH_W-1:0]   = f.depth;
        spare_index               = CFG_IDX_BLUE + 3'($urandom_range(1, 4));
        write_register(CFG_IDX_DEPTH, depth_word);
        write_register(CFG_IDX_RED, f.red);
        write_register(CFG_IDX_GREEN, f.green);
        write_register(CFG_IDX_BLUE, f.blue);
        write_register(spare_index, $urandom);
        cfg_we <= 1'b0;
    endtask

    // Offer one pixel request and return at the edge that takes it. in_valid is only
    // dropped when a gap is drawn, so a busy stream keeps it high across requests.
    task automatic send_pixel(
        input logic [LEVEL_W-1:0] r,
        input logic [LEVEL_W-1:0] g,
        input logic [LEVEL_W-1:0] b
    );
        int gap;
        gap = sender_brisk ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        red_level   <= r;
        green_level <= g;
        blue_level  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Drop the request line and wait until every predicted pixel has come back.
    // Advance one edge first so the checker's count includes the last request.
    task automatic drain_pipeline;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Mostly uniform levels, with the two extremes drawn now and then
    function automatic logic [LEVEL_W-1:0] draw_level;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 8'h00;
        else if (pick == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Receiver: after each result taken, draw how long to hold off. Once every CHOKE_EVERY
    // results the hold is long enough that the four stages fill and in_ready falls.
    initial
    begin : receiver
        int hold;
        int results_taken;
        out_ready    <= 1'b0;
        hold          = $urandom_range(0, STALL_MAX);
        results_taken = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                results_taken++;
                if (results_taken % CHOKE_EVERY == CHOKE_AT)
                    hold = CHOKE_CYCLES;
                else if (receiver_brisk)
                    hold = 0;
                else
                    hold = $urandom_range(0, STALL_MAX);
            end
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: give up well past the slowest legal run
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        format_t            formats[$];
        format_t            f;
        logic [3*LEVEL_W-1:0] probes[3];
        int                 n_items;

        // Initialise every input before the first edge
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_IDX_DEPTH;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        red_level      <= '0;
        green_level    <= '0;
        blue_level     <= '0;
        sender_brisk    = 1'b0;
        receiver_brisk  = 1'b0;

        // Zeros, full scale, and a mix whose low bits the truncating formats must drop
        probes[0] = 24'h00_00_00;
        probes[1] = 24'hFF_FF_FF;
        probes[2] = 24'h07_FC_83;

        // Fixed packings first: RGB/BGR 32-bit, 565 and 555
        formats.push_back({6'd32, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF});
        formats.push_back({6'd32, 32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000});
        formats.push_back({6'd16, 32'h0000_F800, 32'h0000_07E0, 32'h0000_001F});
        formats.push_back({6'd16, 32'h0000_001F, 32'h0000_07E0, 32'h0000_F800});
        formats.push_back({6'd16, 32'h0000_7C00, 32'h0000_03E0, 32'h0000_001F});
        formats.push_back({6'd16, 32'h0000_001F, 32'h0000_03E0, 32'h0000_7C00});
        // Reset format written back: scaling path, exact byte placement
        formats.push_back({DEPTH_RESET, RED_RESET, GREEN_RESET, BLUE_RESET});
        // Depth at both ends of its six bits, empty and fully overlapping masks
        formats.push_back({6'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
        formats.push_back({6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        formats.push_back({6'd1, 32'h8000_0001, 32'h0F0F_0F0F, 32'h0000_0000});
        // Near misses: 565 masks at depth 15, and a red mask whose top byte spills
        // into key bits beyond 32
        formats.push_back({6'd15, 32'h0000_F800, 32'h0000_07E0, 32'h0000_001F});
        formats.push_back({6'd32, 32'hFF00_0000, 32'h00FF_0000, 32'h0000_FF00});
        // Blue mask is not part of the key, so junk there keeps the 565 packing
        formats.push_back({6'd16, 32'h0000_F800, 32'h0000_07E0, 32'($urandom)});
        // Anything goes
        repeat (4)
            formats.push_back({6'($urandom_range(0, 63)), 32'($urandom), 32'($urandom),
                               32'($urandom)});
        formats.push_back({($urandom_range(0, 1) != 0) ? 6'd16 : 6'd32, 32'($urandom),
                           32'($urandom), 32'($urandom)});

        @(posedge clk);
        while (!rst_n) @(posedge clk);

        // Directed: probes under the reset format, then under each fixed packing
        foreach (probes[i])
            send_pixel(probes[i][23:16], probes[i][15:8], probes[i][7:0]);
        drain_pipeline();
        for (int k = 0; k < NAMED_COUNT; k++)
        begin
            apply_format(formats[k]);
            foreach (probes[i])
                send_pixel(probes[i][23:16], probes[i][15:8], probes[i][7:0]);
            drain_pipeline();
        end

        // Random: every format in turn, with idling switched off on either side now and then
        foreach (formats[k])
        begin
            f = formats[k];
            apply_format(f);
            sender_brisk   = ($urandom_range(0, 3) == 0);
            receiver_brisk = ($urandom_range(0, 3) == 0);
            n_items        = $urandom_range(58, 102);
            repeat (n_items)
                send_pixel(draw_level(), draw_level(), draw_level());
            drain_pipeline();
        end

        // Let anything stray surface before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
